// ----- sv/lfbd_pkg.sv -----
// shared types and constants for the lidar frame boundary detector
`timescale 1ns / 1ps
`default_nettype none
package lfbd_pkg;

    localparam int AZ_W          = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_IDX_W     = 2;
    localparam int OUT_SWEEP_W   = 24;
    localparam int SWEEP_BITS_DEF = 24;
    localparam int STEP_W        = AZ_W + 1;
    localparam int GAP_W         = AZ_W + 2;

    localparam logic [GAP_W-1:0] FULL_TURN = GAP_W'(36000);

    localparam logic [CFG_W-1:0] START_ANGLE_RST = CFG_W'(0);
    localparam logic [CFG_W-1:0] DIR_WINDOW_RST  = CFG_W'(200);
    localparam logic [CFG_W-1:0] MIN_SWEEP_RST   = CFG_W'(30000);

    localparam logic [CFG_IDX_W-1:0] CFG_START_ANGLE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_WINDOW  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_SWEEP   = CFG_IDX_W'(2);

    typedef struct packed {
        logic [CFG_W-1:0] start_angle;
        logic [CFG_W-1:0] direction_window;
        logic [CFG_W-1:0] min_publish_sweep;
    } cfg_t;

    typedef struct packed {
        logic frame_end;
        logic ccw;
        logic [OUT_SWEEP_W-1:0] sweep_shown;
    } step_res_t;

endpackage
`default_nettype wire

// ----- sv/lfbd_cfg.sv -----
// configuration register bank
`timescale 1ns / 1ps
`default_nettype none
module lfbd_cfg
    import lfbd_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 cfg_valid,
    output      logic                 cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [CFG_W-1:0]     cfg_data,
    output      cfg_t                 cfg
);

    cfg_t cfg_reg, cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                CFG_START_ANGLE: cfg_next.start_angle       = cfg_data;
                CFG_DIR_WINDOW:  cfg_next.direction_window  = cfg_data;
                CFG_MIN_SWEEP:   cfg_next.min_publish_sweep = cfg_data;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.start_angle       <= START_ANGLE_RST;
            cfg_reg.direction_window  <= DIR_WINDOW_RST;
            cfg_reg.min_publish_sweep <= MIN_SWEEP_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule
`default_nettype wire

// ----- sv/lfbd_step.sv -----
// one azimuth step: direction, wrapped gap, saturating sweep add, crossing test
`timescale 1ns / 1ps
`default_nettype none
module lfbd_step
    import lfbd_pkg::*;
#(
    parameter int SWEEP_BITS = SWEEP_BITS_DEF
) (
    input  wire logic [AZ_W-1:0]       cur,
    input  wire logic [AZ_W-1:0]       last,
    input  wire logic                  nonempty,
    input  wire logic                  ccw_in,
    input  wire logic [SWEEP_BITS-1:0] sweep_in,
    input  wire cfg_t                  cfg,
    output      step_res_t             res,
    output      logic [SWEEP_BITS-1:0] sweep_next
);

    localparam int SUM_W = SWEEP_BITS + 2;
    localparam int EXT_W = SWEEP_BITS + OUT_SWEEP_W;
    localparam logic [EXT_W-1:0] OUT_MAX = EXT_W'({OUT_SWEEP_W{1'b1}});

    logic signed [STEP_W-1:0] d, nd, e;
    logic                     ccw;
    logic signed [GAP_W-1:0]  gap;
    logic signed [SUM_W-1:0]  sum;
    logic [SWEEP_BITS-1:0]    total;
    logic [EXT_W-1:0]         total_ext;
    logic                     wrapped, ahead, past, crossing, fe;

    always_comb begin
        d  = $signed({1'b0, cur}) - $signed({1'b0, last});
        nd = -d;

        // small nonzero step sets the spin direction
        ccw = ccw_in;
        if (d > 0 && d[AZ_W-1:0] < cfg.direction_window) begin
            ccw = 1'b0;
        end else if (nd > 0 && nd[AZ_W-1:0] < cfg.direction_window) begin
            ccw = 1'b1;
        end

        e   = ccw ? nd : d;
        gap = GAP_W'(e);
        if (e < 0) begin
            gap = gap + $signed(FULL_TURN);
        end

        sum = $signed({2'b00, sweep_in}) + SUM_W'(gap);
        if (sum[SUM_W-1]) begin
            total = '0;
        end else if (sum[SWEEP_BITS]) begin
            total = '1;
        end else begin
            total = sum[SWEEP_BITS-1:0];
        end

        // crossing of the start angle in the spin direction
        if (ccw) begin
            wrapped = cur > last;
            ahead   = cfg.start_angle < last;
            past    = cur <= cfg.start_angle;
        end else begin
            wrapped = cur < last;
            ahead   = cfg.start_angle > last;
            past    = cur >= cfg.start_angle;
        end
        crossing = (cur != last) && ((wrapped && (past || ahead)) || (ahead && past));

        fe = crossing && nonempty
             && (total > SWEEP_BITS'(cfg.min_publish_sweep));

        total_ext = EXT_W'(total);

        res.frame_end   = fe;
        res.ccw         = ccw;
        res.sweep_shown = (total_ext > OUT_MAX) ? OUT_SWEEP_W'(OUT_MAX)
                                                 : total_ext[OUT_SWEEP_W-1:0];
        sweep_next      = fe ? '0 : total;
    end

endmodule
`default_nettype wire

// ----- sv/lidar_frame_boundary_detect.sv -----
// top level: input register, step logic with sweep state, result register
//
// channel  dir  handshake                  payload
// s_       in   s_tvalid / s_tready        tdata: azimuth; tuser: frame_nonempty
// m_       out  m_tvalid / m_tready        tdata: sweep_total_out; tuser: ccw;
//                                          tlast: frame_end
// cfg_     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one item per cycle unless m_tready stalls; input register, then result register
// the step logic and the sweep state update sit between the input and result registers
// synchronous active-low reset clears valids, direction, sweep, previous azimuth, config
// a stalled result holds the result register and, behind it, the input register
`timescale 1ns / 1ps
`default_nettype none
module lidar_frame_boundary_detect
    import lfbd_pkg::*;
#(
    parameter int SWEEP_BITS = SWEEP_BITS_DEF
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_tvalid,
    output      logic                   s_tready,
    input  wire logic [AZ_W-1:0]        s_tdata,   // azimuth
    input  wire logic                   s_tuser,   // frame_nonempty
    output      logic                   m_tvalid,
    input  wire logic                   m_tready,
    output      logic [OUT_SWEEP_W-1:0] m_tdata,   // sweep_total_out
    output      logic                   m_tuser,   // counterclockwise
    output      logic                   m_tlast,   // frame_end
    input  wire logic                   cfg_valid,
    output      logic                   cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_W-1:0]       cfg_data
);

    cfg_t cfg;

    logic                  in_valid_reg;
    logic [AZ_W-1:0]       in_az_reg;
    logic                  in_ne_reg;
    logic [AZ_W-1:0]       prev_az_reg;
    logic                  ccw_reg;
    logic [SWEEP_BITS-1:0] sweep_reg;
    logic [SWEEP_BITS-1:0] sweep_next;
    logic                  out_valid_reg;
    step_res_t             out_reg;
    step_res_t             res;
    logic                  advance;

    lfbd_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lfbd_step #(
        .SWEEP_BITS (SWEEP_BITS)
    ) u_step (
        .cur        (in_az_reg),
        .last       (prev_az_reg),
        .nonempty   (in_ne_reg),
        .ccw_in     (ccw_reg),
        .sweep_in   (sweep_reg),
        .cfg        (cfg),
        .res        (res),
        .sweep_next (sweep_next)
    );

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg.sweep_shown;
    assign m_tuser  = out_reg.ccw;
    assign m_tlast  = out_reg.frame_end;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            prev_az_reg   <= '0;
            ccw_reg       <= 1'b0;
            sweep_reg     <= '0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
                prev_az_reg   <= in_az_reg;
                ccw_reg       <= res.ccw;
                sweep_reg     <= sweep_next;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_az_reg <= s_tdata;
            in_ne_reg <= s_tuser;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

endmodule
`default_nettype wire

// ----- sim/lidar_frame_boundary_detect_tb.sv -----
// testbench for the lidar frame boundary detector: queue-fed driver, predictor and result checker
`timescale 1ns / 1ps
module lidar_frame_boundary_detect_tb;
    import lfbd_pkg::*;

    localparam int     WATCHDOG_LIMIT = 2000;
    localparam int     SETTLE_CYCLES  = 4;
    localparam int     CALM_TAIL      = 150;
    localparam longint TURN           = 36000;
    localparam longint SWEEP_SAT      = (64'd1 << SWEEP_BITS_DEF) - 1;
    localparam longint SHOWN_SAT      = (64'd1 << OUT_SWEEP_W) - 1;

    typedef enum {ENT_SAMPLE, ENT_CFG, ENT_DRAIN} ent_kind_t;

    typedef struct {
        ent_kind_t              kind;
        logic [AZ_W-1:0]        az;
        logic                   nonempty;
        logic [CFG_IDX_W-1:0]   idx;
        logic [CFG_W-1:0]       data;
    } ent_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [AZ_W-1:0]        s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_SWEEP_W-1:0] m_tdata;
    logic                   m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_data;

    ent_t      pend_q[$];
    step_res_t boundary_q[$];

    // predictor copy of registers and state
    logic [CFG_W-1:0] start_angle_r = START_ANGLE_RST;
    logic [CFG_W-1:0] dir_window_r  = DIR_WINDOW_RST;
    logic [CFG_W-1:0] min_sweep_r   = MIN_SWEEP_RST;
    logic [AZ_W-1:0]  last_az       = '0;
    logic             spin_ccw      = 1'b0;
    longint           sweep_acc     = 0;

    bit  s_fire, c_fire, busy;
    int  gap_left, stall_left, quiet, idle_cnt, errs;
    logic [AZ_W-1:0] gen_az;
    bit  gen_ccw;

    lidar_frame_boundary_detect DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    function automatic step_res_t track_boundary(input logic [AZ_W-1:0] az, input logic nonempty);
        longint    cur, last, start, win, d, s, gap, total;
        bit        wrapped, past_start, crossing;
        step_res_t r;
        cur   = az;
        last  = last_az;
        start = start_angle_r;
        win   = dir_window_r;
        d     = cur - last;
        if (d > 0 && d < win) begin
            spin_ccw = 1'b0;
        end else if (-d > 0 && -d < win) begin
            spin_ccw = 1'b1;
        end
        s       = spin_ccw ? -1 : 1;
        wrapped = s * (last - cur) > 0;
        gap     = wrapped ? TURN + s * d : s * d;
        total   = sweep_acc + gap;
        if (total < 0) total = 0;
        if (total > SWEEP_SAT) total = SWEEP_SAT;
        sweep_acc = total;
        crossing  = 1'b0;
        if (last != cur) begin
            past_start = s * (start - cur) <= 0;
            crossing   = (wrapped && (past_start || s * (start - last) > 0)) ||
                         (s * (last - start) < 0 && past_start);
        end
        r.frame_end   = crossing && sweep_acc > longint'(min_sweep_r) && nonempty;
        r.ccw         = spin_ccw;
        r.sweep_shown = OUT_SWEEP_W'(sweep_acc > SHOWN_SAT ? SHOWN_SAT : sweep_acc);
        if (r.frame_end) sweep_acc = 0;
        last_az = az;
        return r;
    endfunction

    task automatic push_sample(input logic [AZ_W-1:0] az, input logic nonempty);
        ent_t e;
        e.kind     = ENT_SAMPLE;
        e.az       = az;
        e.nonempty = nonempty;
        e.idx      = '0;
        e.data     = '0;
        pend_q.insert(pend_q.size(), e);
    endtask

    task automatic push_drain();
        ent_t e;
        e.kind     = ENT_DRAIN;
        e.az       = '0;
        e.nonempty = 1'b0;
        e.idx      = '0;
        e.data     = '0;
        pend_q.insert(pend_q.size(), e);
    endtask

    task automatic push_cfg(input logic [CFG_W-1:0] sa, input logic [CFG_W-1:0] win,
                            input logic [CFG_W-1:0] mins);
        ent_t e;
        push_drain();
        e.kind     = ENT_CFG;
        e.az       = '0;
        e.nonempty = 1'b0;
        e.idx      = CFG_START_ANGLE;
        e.data     = sa;
        pend_q.insert(pend_q.size(), e);
        e.idx      = CFG_DIR_WINDOW;
        e.data     = win;
        pend_q.insert(pend_q.size(), e);
        e.idx      = CFG_MIN_SWEEP;
        e.data     = mins;
        pend_q.insert(pend_q.size(), e);
    endtask

    // mostly a steadily spinning head with occasional reversals, plus some noise
    task automatic push_spin(input int n, input int step_hi);
        int stp;
        for (int i = 0; i < n; i++) begin
            if (i == n / 2) push_drain();
            if ($urandom_range(0, 99) < 12) begin
                push_sample(AZ_W'($urandom), 1'($urandom));
            end else begin
                if ($urandom_range(0, 199) == 0) gen_ccw = ~gen_ccw;
                stp = ($urandom_range(0, 19) == 0) ? $urandom_range(step_hi, 20000)
                                                   : $urandom_range(0, step_hi);
                if (gen_ccw) begin
                    gen_az = AZ_W'((int'(gen_az) + 36000 - stp) % 36000);
                end else begin
                    gen_az = AZ_W'((int'(gen_az) + stp) % 36000);
                end
                push_sample(gen_az, $urandom_range(0, 15) != 0);
            end
        end
    endtask

    // acceptance, prediction, result check and watchdog
    always @(posedge aclk) begin
        step_res_t want, got;
        bit        moved;
        if (aresetn) begin
            moved = 1'b0;
            if (m_tvalid && m_tready) begin
                moved   = 1'b1;
                got.frame_end   = m_tlast;
                got.ccw         = m_tuser;
                got.sweep_shown = m_tdata;
                if (boundary_q.size() == 0) begin
                    $error("result with nothing outstanding: sweep %0d", m_tdata);
                    errs++;
                end else begin
                    want = boundary_q.pop_front();
                    if (got.frame_end !== want.frame_end) begin
                        $error("frame_end mismatch: expected %0d, actual %0d",
                               want.frame_end, got.frame_end);
                        errs++;
                    end
                    if (got.ccw !== want.ccw) begin
                        $error("counterclockwise mismatch: expected %0d, actual %0d",
                               want.ccw, got.ccw);
                        errs++;
                    end
                    if (got.sweep_shown !== want.sweep_shown) begin
                        $error("sweep_total_out mismatch: expected %0d, actual %0d",
                               want.sweep_shown, got.sweep_shown);
                        errs++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                moved = 1'b1;
                boundary_q.insert(boundary_q.size(), track_boundary(s_tdata, s_tuser));
                s_fire = 1'b1;
            end
            if (cfg_valid && cfg_ready) begin
                moved = 1'b1;
                case (cfg_index)
                    CFG_START_ANGLE: start_angle_r = cfg_data;
                    CFG_DIR_WINDOW:  dir_window_r  = cfg_data;
                    CFG_MIN_SWEEP:   min_sweep_r   = cfg_data;
                    default: ;
                endcase
                c_fire = 1'b1;
            end
            if (boundary_q.size() == 0 && !s_tvalid) begin
                quiet++;
            end else begin
                quiet = 0;
            end
            idle_cnt = moved ? 0 : idle_cnt + 1;
            if (idle_cnt >= WATCHDOG_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // sender
    always @(negedge aclk) begin
        ent_t e;
        logic nxt_sv, nxt_cv;
        if (aresetn) begin
            if (s_fire || c_fire) begin
                busy   = 1'b0;
                s_fire = 1'b0;
                c_fire = 1'b0;
                if (pend_q.size() >= CALM_TAIL && $urandom_range(0, 3) == 0)
                    gap_left = $urandom_range(1, 10);
            end
            if (!busy) begin
                nxt_sv = 1'b0;
                nxt_cv = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pend_q.size() > 0) begin
                    case (pend_q[0].kind)
                        ENT_SAMPLE: begin
                            e = pend_q.pop_front();
                            s_tdata <= e.az;
                            s_tuser <= e.nonempty;
                            nxt_sv  = 1'b1;
                            busy    = 1'b1;
                        end
                        ENT_CFG: begin
                            if (quiet >= SETTLE_CYCLES) begin
                                e = pend_q.pop_front();
                                cfg_index <= e.idx;
                                cfg_data  <= e.data;
                                nxt_cv    = 1'b1;
                                busy      = 1'b1;
                            end
                        end
                        default: begin
                            if (quiet >= SETTLE_CYCLES) e = pend_q.pop_front();
                        end
                    endcase
                end
                s_tvalid  <= nxt_sv;
                cfg_valid <= nxt_cv;
            end
        end
    end

    // receiver
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if (pend_q.size() >= CALM_TAIL && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 10);
        end
    end

    initial begin
        logic [AZ_W-1:0] az;
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = 1'b0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_START_ANGLE;
        cfg_data  = '0;
        gen_az    = '0;
        gen_ccw   = 1'b0;

        // directed: small steps, no move, wraps both ways, reversal, out-of-range azimuths
        push_sample(16'd100, 1'b1);
        push_sample(16'd150, 1'b1);
        push_sample(16'd150, 1'b1);
        push_sample(16'd10000, 1'b1);
        push_sample(16'd20000, 1'b1);
        push_sample(16'd30000, 1'b1);
        push_sample(16'd35999, 1'b1);
        push_sample(16'd10, 1'b1);
        push_sample(16'd35950, 1'b1);
        push_sample(16'd35800, 1'b1);
        push_sample(16'd100, 1'b0);
        push_sample(16'd0, 1'b1);
        push_sample(16'd35999, 1'b1);
        push_sample(16'd65535, 1'b0);
        push_sample(16'd0, 1'b1);
        push_sample(16'd36000, 1'b1);
        push_sample(16'd1, 1'b0);
        push_sample(16'd199, 1'b1);
        push_sample(16'd0, 1'b1);
        push_sample(16'd0, 1'b0);

        push_cfg(16'd0, 16'd1, 16'd0);
        push_spin(140, 300);
        push_cfg(16'd35999, 16'd36000, 16'd65535);
        push_spin(140, 1500);
        push_cfg(16'd65535, 16'd0, 16'd1000);
        push_spin(140, 600);

        // zero window keeps the spin as it was; if clockwise, backward steps saturate the sweep
        push_cfg(16'd18000, 16'd0, 16'd65535);
        az = 16'd20000;
        for (int i = 0; i < 500; i++) begin
            az = AZ_W'((int'(az) + 36000 - $urandom_range(1, 50)) % 36000);
            push_sample(az, (i >= 470) ? 1'($urandom) : 1'b0);
        end

        push_cfg(16'd18000, 16'd200, 16'd30000);
        push_spin(140, 400);
        push_cfg(16'd9000, 16'd500, 16'd5000);
        push_spin(140, 800);
        for (int k = 0; k < 3; k++) begin
            push_cfg(CFG_W'($urandom_range(0, 35999)), CFG_W'($urandom_range(1, 36000)),
                     CFG_W'($urandom_range(0, 40000)));
            push_spin(140, $urandom_range(100, 1500));
        end

        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pend_q.size() > 0 || busy || boundary_q.size() > 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (errs == 0 && boundary_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
